[design/kvt_pkg.sv]
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and codes for the fixed-slot key/value table.
// ----------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

  // Width of staged byte counts and byte counters (counts 0 to 127)
  localparam int CNT_W = 7;

  typedef enum logic [1:0] {
    MODE_SET    = 2'd0,
    MODE_GET    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_LIST   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PART_KEY   = 2'd0,
    PART_VALUE = 2'd1,
    PART_EXEC  = 2'd2,
    PART_NONE  = 2'd3
  } part_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADKEY   = 3'd1,
    ST_RANGE    = 3'd2,
    ST_NOSPACE  = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_CMP_RD,
    S_CMP_CHK,
    S_SET_KEY,
    S_SET_VAL,
    S_COMMIT,
    S_LIST,
    S_HDR,
    S_DATA_RD,
    S_DATA_EMIT
  } state_t;

  // Staged operand counts seen by the sequencer
  typedef struct packed {
    logic [CNT_W-1:0] kcnt;
    logic [CNT_W-1:0] vcnt;
  } stg_t;

endpackage

`default_nettype wire

[design/kvt_ifs.sv]
// ----------------------------------------------------------------------------
// kvt_ifs
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface kvt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [1:0]  part;
  logic [7:0]  data;
  logic [15:0] capacity;
  logic [3:0]  rank;

  modport source(output valid, output mode, output part, output data,
                 output capacity, output rank, input ready);
  modport sink(input valid, input mode, input part, input data,
               input capacity, input rank, output ready);
endinterface

interface kvt_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [2:0] status;
  logic [5:0] length;
  logic [4:0] entry_count;
  logic [7:0] data_out;
  logic       last;

  modport source(output valid, output kind, output status, output length,
                 output entry_count, output data_out, output last, input ready);
  modport sink(input valid, input kind, input status, input length,
               input entry_count, input data_out, input last, output ready);
endinterface

`default_nettype wire

[design/kvt_ram.sv]
// ----------------------------------------------------------------------------
// kvt_ram
// Single-port-write, single-port-read byte memory, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata_r
);

  logic [7:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, hold data when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/kvt_stage.sv]
// ----------------------------------------------------------------------------
// kvt_stage
// Staging buffer for the key and value bytes of the pending operation.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_stage #(
  parameter int KEY_BYTES   = 16,
  parameter int VALUE_BYTES = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     wr,
  input  wire logic [1:0]               part,
  input  wire logic [7:0]               data,
  input  wire logic                     clr,
  input  wire logic [kvt_pkg::CNT_W-1:0] idx,
  output kvt_pkg::stg_t                 stg,
  output logic      [7:0]               key_byte,
  output logic      [7:0]               val_byte
);

  localparam int KIW = $clog2(KEY_BYTES);
  localparam int VIW = (VALUE_BYTES > 1) ? $clog2(VALUE_BYTES) : 1;

  logic [7:0] key_r [KEY_BYTES];
  logic [7:0] val_r [VALUE_BYTES];
  logic [kvt_pkg::CNT_W-1:0] kcnt_r, vcnt_r;
  logic ended_r;

  // Counts and terminator flag
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      kcnt_r  <= '0;
      vcnt_r  <= '0;
      ended_r <= 1'b0;
    end else if (wr) begin
      if (part == kvt_pkg::PART_KEY && !ended_r) begin
        if (data == 8'd0) begin
          ended_r <= 1'b1;
        end else if (kcnt_r < kvt_pkg::CNT_W'(KEY_BYTES)) begin
          kcnt_r <= kcnt_r + 1'b1;
        end
      end else if (part == kvt_pkg::PART_VALUE) begin
        if (vcnt_r <= kvt_pkg::CNT_W'(VALUE_BYTES)) begin
          vcnt_r <= vcnt_r + 1'b1;
        end
      end
    end
  end

  // Byte storage, drop bytes past capacity
  always_ff @(posedge clk) begin
    if (wr && part == kvt_pkg::PART_KEY && !ended_r && data != 8'd0 &&
        kcnt_r < kvt_pkg::CNT_W'(KEY_BYTES)) begin
      key_r[kcnt_r[KIW-1:0]] <= data;
    end
    if (wr && part == kvt_pkg::PART_VALUE &&
        vcnt_r < kvt_pkg::CNT_W'(VALUE_BYTES)) begin
      val_r[vcnt_r[VIW-1:0]] <= data;
    end
  end

  assign stg      = '{kcnt: kcnt_r, vcnt: vcnt_r};
  assign key_byte = key_r[idx[KIW-1:0]];
  assign val_byte = val_r[idx[VIW-1:0]];

endmodule

`default_nettype wire

[design/kvt_seq.sv]
// ----------------------------------------------------------------------------
// kvt_seq
// Operation sequencer: slot search, memory read-modify-write, result words.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_seq #(
  parameter int ENTRIES     = 16,
  parameter int KEY_BYTES   = 16,
  parameter int VALUE_BYTES = 32,
  parameter int KAW         = 8,
  parameter int VAW         = 9
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // command words
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_mode,
  input  wire logic [1:0]                in_part,
  input  wire logic [15:0]               in_capacity,
  input  wire logic [3:0]                in_rank,
  // staging buffer
  input  wire kvt_pkg::stg_t             stg,
  input  wire logic [7:0]                key_byte,
  output logic [kvt_pkg::CNT_W-1:0]      byte_idx,
  output logic                           stg_clr,
  // key memory
  output logic                           key_we,
  output logic                           key_re,
  output logic [KAW-1:0]                 key_addr,
  input  wire logic [7:0]                key_rdata,
  // value memory
  output logic                           val_we,
  output logic                           val_re,
  output logic [VAW-1:0]                 val_addr,
  input  wire logic [7:0]                val_rdata,
  // result words
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_kind,
  output logic [2:0]                     out_status,
  output logic [5:0]                     out_length,
  output logic [4:0]                     out_entry_count,
  output logic [7:0]                     out_data_out,
  output logic                           out_last
);

  localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int UW = $clog2(ENTRIES + 1);
  localparam int CW = kvt_pkg::CNT_W;

  kvt_pkg::state_t state_r, state_nxt;

  logic [1:0]    mode_r,     mode_nxt;
  logic [15:0]   cap_r,      cap_nxt;
  logic [3:0]    rank_r,     rank_nxt;
  logic [SW-1:0] slot_r,     slot_nxt;
  logic [CW-1:0] byte_r,     byte_nxt;
  logic [UW-1:0] seen_r,     seen_nxt;
  logic          free_ok_r,  free_ok_nxt;
  logic [SW-1:0] free_slot_r, free_slot_nxt;
  logic          new_r,      new_nxt;
  logic          strm_r,     strm_nxt;
  logic [2:0]    hdr_st_r,   hdr_st_nxt;
  logic [5:0]    hdr_len_r,  hdr_len_nxt;
  logic [UW-1:0] ucnt_r,     ucnt_nxt;

  logic          used_r [ENTRIES];
  logic [CW-1:0] klen_r [ENTRIES];
  logic [CW-1:0] vlen_r [ENTRIES];
  logic          meta_clr, meta_set, meta_vlen;

  logic       out_valid_r, out_valid_nxt;
  logic       kind_r, kind_nxt, last_r, last_nxt;
  logic [2:0] ost_r, ost_nxt;
  logic [5:0] olen_r, olen_nxt;
  logic [4:0] ocnt_r, ocnt_nxt;
  logic [7:0] odat_r, odat_nxt;

  logic exec, out_free, set_err, slot_hit, last_slot, byte_ok, key_end, val_end;
  logic found, miss, nf, free_any, list_hit, strm_end;
  logic [SW-1:0] free_sel;
  logic [CW-1:0] cur_vlen;

  // Event decode
  always_comb begin
    exec      = in_valid && in_ready && in_part == kvt_pkg::PART_EXEC;
    out_free  = !out_valid_r || out_ready;
    set_err   = (stg.vcnt > CW'(VALUE_BYTES)) || (stg.kcnt == '0) ||
                (stg.kcnt >= CW'(KEY_BYTES));
    slot_hit  = used_r[slot_r] && klen_r[slot_r] == stg.kcnt;
    last_slot = slot_r == SW'(ENTRIES - 1);
    byte_ok   = key_rdata == key_byte;
    key_end   = (byte_r + 1'b1) == stg.kcnt;
    val_end   = (byte_r + 1'b1) == stg.vcnt;
    strm_end  = (byte_r + 1'b1) == CW'(hdr_len_r);
    found     = (state_r == kvt_pkg::S_FIND && slot_hit && stg.kcnt == '0) ||
                (state_r == kvt_pkg::S_CMP_CHK && byte_ok && key_end);
    miss      = (state_r == kvt_pkg::S_FIND && !slot_hit) ||
                (state_r == kvt_pkg::S_CMP_CHK && !byte_ok);
    nf        = miss && last_slot;
    free_any  = free_ok_r || (state_r == kvt_pkg::S_FIND && !used_r[slot_r]);
    free_sel  = free_ok_r ? free_slot_r : slot_r;
    list_hit  = used_r[slot_r] && (32'(seen_r) == 32'(rank_r));
    cur_vlen  = vlen_r[slot_r];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kvt_pkg::S_IDLE: begin
        if (exec) begin
          unique case (kvt_pkg::mode_t'(in_mode))
            kvt_pkg::MODE_SET:  state_nxt = set_err ? kvt_pkg::S_HDR : kvt_pkg::S_FIND;
            kvt_pkg::MODE_LIST: state_nxt = kvt_pkg::S_LIST;
            default:            state_nxt = kvt_pkg::S_FIND;
          endcase
        end
      end
      kvt_pkg::S_FIND, kvt_pkg::S_CMP_CHK: begin
        if (found) begin
          if (mode_r == kvt_pkg::MODE_SET) begin
            state_nxt = (stg.vcnt == '0) ? kvt_pkg::S_COMMIT : kvt_pkg::S_SET_VAL;
          end else begin
            state_nxt = kvt_pkg::S_HDR;
          end
        end else if (nf) begin
          state_nxt = (mode_r == kvt_pkg::MODE_SET && free_any) ?
                      kvt_pkg::S_SET_KEY : kvt_pkg::S_HDR;
        end else if (miss) begin
          state_nxt = kvt_pkg::S_FIND;
        end else begin
          state_nxt = kvt_pkg::S_CMP_RD;
        end
      end
      kvt_pkg::S_CMP_RD:  state_nxt = kvt_pkg::S_CMP_CHK;
      kvt_pkg::S_SET_KEY: begin
        if (key_end) begin
          state_nxt = (stg.vcnt == '0) ? kvt_pkg::S_COMMIT : kvt_pkg::S_SET_VAL;
        end
      end
      kvt_pkg::S_SET_VAL: begin
        if (val_end) begin
          state_nxt = kvt_pkg::S_COMMIT;
        end
      end
      kvt_pkg::S_COMMIT:  state_nxt = kvt_pkg::S_HDR;
      kvt_pkg::S_LIST: begin
        if (list_hit || last_slot) begin
          state_nxt = kvt_pkg::S_HDR;
        end
      end
      kvt_pkg::S_HDR: begin
        if (out_free) begin
          state_nxt = strm_r ? kvt_pkg::S_DATA_RD : kvt_pkg::S_IDLE;
        end
      end
      kvt_pkg::S_DATA_RD: state_nxt = kvt_pkg::S_DATA_EMIT;
      kvt_pkg::S_DATA_EMIT: begin
        if (out_free) begin
          state_nxt = strm_end ? kvt_pkg::S_IDLE : kvt_pkg::S_DATA_RD;
        end
      end
      default: state_nxt = kvt_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    mode_nxt      = mode_r;
    cap_nxt       = cap_r;
    rank_nxt      = rank_r;
    slot_nxt      = slot_r;
    byte_nxt      = byte_r;
    seen_nxt      = seen_r;
    free_ok_nxt   = free_ok_r;
    free_slot_nxt = free_slot_r;
    new_nxt       = new_r;
    strm_nxt      = strm_r;
    hdr_st_nxt    = hdr_st_r;
    hdr_len_nxt   = hdr_len_r;
    ucnt_nxt      = ucnt_r;
    meta_clr      = 1'b0;
    meta_set      = 1'b0;
    meta_vlen     = 1'b0;
    stg_clr       = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    ost_nxt       = ost_r;
    olen_nxt      = olen_r;
    ocnt_nxt      = ocnt_r;
    odat_nxt      = odat_r;
    last_nxt      = last_r;
    key_we        = 1'b0;
    key_re        = 1'b0;
    val_we        = 1'b0;
    val_re        = 1'b0;

    unique case (state_r)
      kvt_pkg::S_IDLE: begin
        if (exec) begin
          mode_nxt    = in_mode;
          cap_nxt     = in_capacity;
          rank_nxt    = in_rank;
          slot_nxt    = '0;
          byte_nxt    = '0;
          seen_nxt    = '0;
          free_ok_nxt = 1'b0;
          new_nxt     = 1'b0;
          strm_nxt    = 1'b0;
          hdr_len_nxt = '0;
          hdr_st_nxt  = (stg.vcnt > CW'(VALUE_BYTES)) ? kvt_pkg::ST_RANGE :
                                                         kvt_pkg::ST_BADKEY;
        end
      end
      kvt_pkg::S_FIND, kvt_pkg::S_CMP_CHK: begin
        // remember the lowest free slot passed
        if (state_r == kvt_pkg::S_FIND && !used_r[slot_r] && !free_ok_r) begin
          free_ok_nxt   = 1'b1;
          free_slot_nxt = slot_r;
        end
        if (found) begin
          byte_nxt    = '0;
          hdr_st_nxt  = kvt_pkg::ST_OK;
          hdr_len_nxt = '0;
          if (mode_r == kvt_pkg::MODE_GET) begin
            hdr_len_nxt = 6'(cur_vlen);
            if (cap_r < 16'(cur_vlen)) begin
              hdr_st_nxt = kvt_pkg::ST_RANGE;
            end else begin
              strm_nxt = cur_vlen != '0;
            end
          end else if (mode_r == kvt_pkg::MODE_REMOVE) begin
            meta_clr = 1'b1;
            if (ucnt_r != '0) begin
              ucnt_nxt = ucnt_r - 1'b1;
            end
          end
        end else if (nf) begin
          hdr_len_nxt = '0;
          if (mode_r == kvt_pkg::MODE_SET) begin
            if (free_any) begin
              slot_nxt = free_sel;
              new_nxt  = 1'b1;
              byte_nxt = '0;
            end else begin
              hdr_st_nxt = kvt_pkg::ST_NOSPACE;
            end
          end else begin
            hdr_st_nxt = kvt_pkg::ST_NOTFOUND;
          end
        end else if (miss) begin
          slot_nxt = slot_r + 1'b1;
          byte_nxt = '0;
        end else if (state_r == kvt_pkg::S_CMP_CHK) begin
          byte_nxt = byte_r + 1'b1;
        end else begin
          byte_nxt = '0;
        end
      end
      kvt_pkg::S_CMP_RD: key_re = 1'b1;
      kvt_pkg::S_SET_KEY: begin
        key_we   = 1'b1;
        byte_nxt = key_end ? '0 : byte_r + 1'b1;
      end
      kvt_pkg::S_SET_VAL: begin
        val_we   = 1'b1;
        byte_nxt = byte_r + 1'b1;
      end
      kvt_pkg::S_COMMIT: begin
        meta_vlen   = 1'b1;
        meta_set    = new_r;
        hdr_st_nxt  = kvt_pkg::ST_OK;
        hdr_len_nxt = '0;
        if (new_r) begin
          ucnt_nxt = ucnt_r + 1'b1;
        end
      end
      kvt_pkg::S_LIST: begin
        if (list_hit) begin
          hdr_st_nxt  = kvt_pkg::ST_OK;
          hdr_len_nxt = 6'(klen_r[slot_r]);
          strm_nxt    = klen_r[slot_r] != '0;
          byte_nxt    = '0;
        end else if (last_slot) begin
          hdr_st_nxt  = kvt_pkg::ST_NOTFOUND;
          hdr_len_nxt = '0;
        end else begin
          slot_nxt = slot_r + 1'b1;
          if (used_r[slot_r]) begin
            seen_nxt = seen_r + 1'b1;
          end
        end
      end
      kvt_pkg::S_HDR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = 1'b0;
          ost_nxt       = hdr_st_r;
          olen_nxt      = hdr_len_r;
          ocnt_nxt      = 5'(ucnt_r);
          odat_nxt      = '0;
          last_nxt      = !strm_r;
          stg_clr       = !strm_r;
        end
      end
      kvt_pkg::S_DATA_RD: begin
        key_re = mode_r == kvt_pkg::MODE_LIST;
        val_re = mode_r != kvt_pkg::MODE_LIST;
      end
      kvt_pkg::S_DATA_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = 1'b1;
          ost_nxt       = kvt_pkg::ST_OK;
          olen_nxt      = hdr_len_r;
          ocnt_nxt      = 5'(ucnt_r);
          odat_nxt      = (mode_r == kvt_pkg::MODE_LIST) ? key_rdata : val_rdata;
          last_nxt      = strm_end;
          stg_clr       = strm_end;
          byte_nxt      = byte_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kvt_pkg::S_IDLE;
      ucnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ucnt_r      <= ucnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Operation and result payload registers
  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    cap_r       <= cap_nxt;
    rank_r      <= rank_nxt;
    slot_r      <= slot_nxt;
    byte_r      <= byte_nxt;
    seen_r      <= seen_nxt;
    free_ok_r   <= free_ok_nxt;
    free_slot_r <= free_slot_nxt;
    new_r       <= new_nxt;
    strm_r      <= strm_nxt;
    hdr_st_r    <= hdr_st_nxt;
    hdr_len_r   <= hdr_len_nxt;
    kind_r      <= kind_nxt;
    ost_r       <= ost_nxt;
    olen_r      <= olen_nxt;
    ocnt_r      <= ocnt_nxt;
    odat_r      <= odat_nxt;
    last_r      <= last_nxt;
  end

  // Slot metadata, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        used_r[i] <= 1'b0;
        klen_r[i] <= '0;
        vlen_r[i] <= '0;
      end
    end else if (meta_clr) begin
      used_r[slot_r] <= 1'b0;
      klen_r[slot_r] <= '0;
      vlen_r[slot_r] <= '0;
    end else if (meta_vlen) begin
      vlen_r[slot_r] <= stg.vcnt;
      if (meta_set) begin
        used_r[slot_r] <= 1'b1;
        klen_r[slot_r] <= stg.kcnt;
      end
    end
  end

  assign in_ready        = state_r == kvt_pkg::S_IDLE;
  assign byte_idx        = byte_r;
  assign key_addr        = KAW'(slot_r) * KAW'(KEY_BYTES) + KAW'(byte_r);
  assign val_addr        = VAW'(slot_r) * VAW'(VALUE_BYTES) + VAW'(byte_r);
  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_status      = ost_r;
  assign out_length      = olen_r;
  assign out_entry_count = ocnt_r;
  assign out_data_out    = odat_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire

[design/attribute_key_value_table.sv]
// ----------------------------------------------------------------------------
// attribute_key_value_table
// Fixed-slot table of short byte-string keys with byte-string values.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries command words: key bytes (part 0), value bytes (part 1),
//   then one execute word (part 2) whose mode picks set, get, remove or
//   list. A zero key byte ends the key. out_ch returns one header word per
//   execute, followed for a good get or list by one data word per byte,
//   with last set on the final word of the operation.
//   Key and value bytes are taken one per cycle while the sequencer is
//   idle. An execute word holds in_ch.ready low while the sequencer works:
//   the slot search steps through the slots and compares key bytes by a
//   key memory read then a check, a new set entry writes each key and
//   value byte, and each data word is one key or value memory read, then
//   the result register. Reset clears slot metadata, the entry count and
//   the staged bytes at once; the byte memories need no clearing pass.
//   When out_ch stalls the result register holds its word and the
//   sequencer waits.
// ----------------------------------------------------------------------------
`default_nettype none

module attribute_key_value_table #(
  parameter int ENTRIES     = 16,
  parameter int KEY_BYTES   = 16,
  parameter int VALUE_BYTES = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kvt_in_if.sink     in_ch,
  kvt_out_if.source  out_ch
);

  localparam int KDEPTH = ENTRIES * KEY_BYTES;
  localparam int VDEPTH = ENTRIES * VALUE_BYTES;
  localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
  localparam int VAW    = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;

  kvt_pkg::stg_t stg;
  logic [7:0] key_byte, val_byte, key_rdata, val_rdata;
  logic [kvt_pkg::CNT_W-1:0] byte_idx;
  logic stg_clr, key_we, key_re, val_we, val_re;
  logic [KAW-1:0] key_addr;
  logic [VAW-1:0] val_addr;

  // Stage incoming key and value bytes
  kvt_stage #(
    .KEY_BYTES   (KEY_BYTES),
    .VALUE_BYTES (VALUE_BYTES)
  ) u_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (in_ch.valid && in_ch.ready),
    .part     (in_ch.part),
    .data     (in_ch.data),
    .clr      (stg_clr),
    .idx      (byte_idx),
    .stg      (stg),
    .key_byte (key_byte),
    .val_byte (val_byte)
  );

  // Key bytes of every slot
  kvt_ram #(
    .DEPTH (KDEPTH),
    .AW    (KAW)
  ) u_key_ram (
    .clk     (clk),
    .we      (key_we),
    .waddr   (key_addr),
    .wdata   (key_byte),
    .re      (key_re),
    .raddr   (key_addr),
    .rdata_r (key_rdata)
  );

  // Value bytes of every slot
  kvt_ram #(
    .DEPTH (VDEPTH),
    .AW    (VAW)
  ) u_val_ram (
    .clk     (clk),
    .we      (val_we),
    .waddr   (val_addr),
    .wdata   (val_byte),
    .re      (val_re),
    .raddr   (val_addr),
    .rdata_r (val_rdata)
  );

  // Operation sequencer
  kvt_seq #(
    .ENTRIES     (ENTRIES),
    .KEY_BYTES   (KEY_BYTES),
    .VALUE_BYTES (VALUE_BYTES),
    .KAW         (KAW),
    .VAW         (VAW)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_mode         (in_ch.mode),
    .in_part         (in_ch.part),
    .in_capacity     (in_ch.capacity),
    .in_rank         (in_ch.rank),
    .stg             (stg),
    .key_byte        (key_byte),
    .byte_idx        (byte_idx),
    .stg_clr         (stg_clr),
    .key_we          (key_we),
    .key_re          (key_re),
    .key_addr        (key_addr),
    .key_rdata       (key_rdata),
    .val_we          (val_we),
    .val_re          (val_re),
    .val_addr        (val_addr),
    .val_rdata       (val_rdata),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_kind        (out_ch.kind),
    .out_status      (out_ch.status),
    .out_length      (out_ch.length),
    .out_entry_count (out_ch.entry_count),
    .out_data_out    (out_ch.data_out),
    .out_last        (out_ch.last)
  );

`ifndef NO_ASSERTIONS
  // An execute word always starts a busy sequence
  a_exec_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.part == kvt_pkg::PART_EXEC |=> !in_ch.ready)
    else $error("execute word did not start the sequencer");

  // Data words only follow a good get or list
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind |-> out_ch.status == kvt_pkg::ST_OK)
    else $error("data word with error status");

  // Error headers end the operation
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != kvt_pkg::ST_OK |-> out_ch.last && !out_ch.kind)
    else $error("error header not last");

  // Entry count never exceeds the slot count
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> int'(out_ch.entry_count) <= ENTRIES)
    else $error("entry count above slot count");
`endif

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the key/value table: streams key, value and
// execute words, predicts every header and data word, checks them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int NSLOT = 16;
  localparam int KMAX  = 16;
  localparam int VMAX  = 32;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [5:0] length;
    logic [4:0] entry_count;
    logic [7:0] data_out;
    logic       last;
  } result_t;

  logic clk;
  logic rst_n;
  kvt_in_if  in_ch();
  kvt_out_if out_ch();

  attribute_key_value_table DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Shadow table state
  logic [7:0] tbl_key [NSLOT][KMAX];
  int         tbl_klen [NSLOT];
  logic [7:0] tbl_val [NSLOT][VMAX];
  int         tbl_vlen [NSLOT];
  bit         tbl_used [NSLOT];
  int         tbl_count;
  logic [7:0] stg_key [KMAX];
  int         stg_kcnt;
  logic [7:0] stg_val [VMAX];
  int         stg_vcnt;
  bit         stg_ended;

  result_t pending_results[$];
  int      errors;
  int      results_seen;
  int      ops_sent;
  longint  cycles;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("Mismatch: %s", what);
  endtask

  function automatic void push_result(logic kind, kvt_pkg::status_t st, int len,
                                      logic [7:0] d, logic last);
    result_t r;
    r.kind = kind; r.status = st; r.length = len[5:0];
    r.entry_count = tbl_count[4:0]; r.data_out = d; r.last = last;
    pending_results.push_back(r);
  endfunction

  function automatic int find_slot();
    int j;
    for (int i = 0; i < NSLOT; i++) begin
      if (!tbl_used[i] || tbl_klen[i] != stg_kcnt) continue;
      for (j = 0; j < stg_kcnt && j < KMAX; j++)
        if (tbl_key[i][j] != stg_key[j]) break;
      if (j == stg_kcnt) return i;
    end
    return NSLOT;
  endfunction

  function automatic void store_value(int s);
    for (int k = 0; k < stg_vcnt && k < VMAX; k++) tbl_val[s][k] = stg_val[k];
    tbl_vlen[s] = stg_vcnt;
  endfunction

  // Predict the words caused by one command word
  function automatic void predict_word(kvt_pkg::mode_t m, kvt_pkg::part_t p,
                                       logic [7:0] d, logic [15:0] cap,
                                       logic [3:0] rk);
    int s;
    int seen;
    bit done;
    if (p == kvt_pkg::PART_KEY) begin
      if (stg_ended) return;
      if (d == 0) stg_ended = 1;
      else if (stg_kcnt < KMAX) begin
        stg_key[stg_kcnt] = d; stg_kcnt++;
      end
      return;
    end
    if (p == kvt_pkg::PART_VALUE) begin
      if (stg_vcnt < VMAX) stg_val[stg_vcnt] = d;
      if (stg_vcnt <= VMAX) stg_vcnt++;
      return;
    end
    if (p != kvt_pkg::PART_EXEC) return;
    case (m)
      kvt_pkg::MODE_SET: begin
        if (stg_vcnt > VMAX) push_result(0, kvt_pkg::ST_RANGE, 0, 0, 1);
        else if (stg_kcnt == 0 || stg_kcnt >= KMAX)
          push_result(0, kvt_pkg::ST_BADKEY, 0, 0, 1);
        else begin
          s = find_slot();
          if (s < NSLOT) begin
            store_value(s);
            push_result(0, kvt_pkg::ST_OK, 0, 0, 1);
          end else begin
            done = 0;
            for (int i = 0; i < NSLOT && !done; i++) begin
              if (!tbl_used[i]) begin
                for (int k = 0; k < stg_kcnt; k++) tbl_key[i][k] = stg_key[k];
                tbl_klen[i] = stg_kcnt;
                store_value(i);
                tbl_used[i] = 1;
                tbl_count++;
                done = 1;
              end
            end
            push_result(0, done ? kvt_pkg::ST_OK : kvt_pkg::ST_NOSPACE, 0, 0, 1);
          end
        end
      end
      kvt_pkg::MODE_GET: begin
        s = find_slot();
        if (s >= NSLOT) push_result(0, kvt_pkg::ST_NOTFOUND, 0, 0, 1);
        else if (cap < tbl_vlen[s]) push_result(0, kvt_pkg::ST_RANGE, tbl_vlen[s], 0, 1);
        else begin
          push_result(0, kvt_pkg::ST_OK, tbl_vlen[s], 0, tbl_vlen[s] == 0);
          for (int k = 0; k < tbl_vlen[s]; k++)
            push_result(1, kvt_pkg::ST_OK, tbl_vlen[s], tbl_val[s][k],
                        k + 1 == tbl_vlen[s]);
        end
      end
      kvt_pkg::MODE_REMOVE: begin
        s = find_slot();
        if (s >= NSLOT) push_result(0, kvt_pkg::ST_NOTFOUND, 0, 0, 1);
        else begin
          tbl_used[s] = 0; tbl_vlen[s] = 0; tbl_klen[s] = 0;
          if (tbl_count > 0) tbl_count--;
          push_result(0, kvt_pkg::ST_OK, 0, 0, 1);
        end
      end
      default: begin
        seen = 0;
        done = 0;
        for (int i = 0; i < NSLOT && !done; i++) begin
          if (!tbl_used[i]) continue;
          if (seen == rk) begin
            push_result(0, kvt_pkg::ST_OK, tbl_klen[i], 0, tbl_klen[i] == 0);
            for (int k = 0; k < tbl_klen[i]; k++)
              push_result(1, kvt_pkg::ST_OK, tbl_klen[i], tbl_key[i][k],
                          k + 1 == tbl_klen[i]);
            done = 1;
          end
          seen++;
        end
        if (!done) push_result(0, kvt_pkg::ST_NOTFOUND, 0, 0, 1);
      end
    endcase
    stg_kcnt = 0; stg_vcnt = 0; stg_ended = 0;
  endfunction

  // Send one command word, then predict it once it is taken
  task automatic send_word(kvt_pkg::mode_t m, kvt_pkg::part_t p, logic [7:0] d,
                           logic [15:0] cap = 0, logic [3:0] rk = 0);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 1)) gap = 0;
    // drop valid only while idling between words
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1; in_ch.mode <= m; in_ch.part <= p; in_ch.data <= d;
    in_ch.capacity <= cap; in_ch.rank <= rk;
    do @(posedge clk); while (!in_ch.ready);
    predict_word(m, p, d, cap, rk);
    if (p == kvt_pkg::PART_EXEC) ops_sent++;
  endtask

  // Stream a key (no terminator), optional value bytes, then execute
  task automatic run_op(kvt_pkg::mode_t m, logic [7:0] key[$], logic [7:0] val[$],
                        logic [15:0] cap = 16'hFFFF, logic [3:0] rk = 0);
    foreach (key[i]) send_word(m, kvt_pkg::PART_KEY, key[i]);
    foreach (val[i]) send_word(m, kvt_pkg::PART_VALUE, val[i]);
    send_word(m, kvt_pkg::PART_EXEC, 8'($urandom), cap, rk);
  endtask

  // Result checker with random back-pressure
  initial begin
    int stall;
    out_ch.ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      stall = $urandom_range(0, 1) ? 0 : $urandom_range(0, 12);
      // drop ready only while stalling
      if (stall > 0) begin
        out_ch.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1;
      do @(posedge clk); while (!out_ch.valid);
      results_seen++;
      if (pending_results.size() == 0) report("result word with nothing expected");
      else begin
        result_t e;
        e = pending_results.pop_front();
        if (out_ch.kind !== e.kind) report($sformatf("kind %0b exp %0b", out_ch.kind, e.kind));
        if (out_ch.status !== e.status)
          report($sformatf("status %0d exp %0d", out_ch.status, e.status));
        if (out_ch.length !== e.length)
          report($sformatf("length %0d exp %0d", out_ch.length, e.length));
        if (out_ch.entry_count !== e.entry_count)
          report($sformatf("entry_count %0d exp %0d", out_ch.entry_count, e.entry_count));
        if (out_ch.data_out !== e.data_out)
          report($sformatf("data_out %0h exp %0h", out_ch.data_out, e.data_out));
        if (out_ch.last !== e.last) report($sformatf("last %0b exp %0b", out_ch.last, e.last));
      end
    end
  end

  function automatic void make_bytes(ref logic [7:0] q[$], input int n, input bit nonzero);
    q.delete();
    for (int i = 0; i < n; i++) q.push_back(nonzero ? 8'($urandom_range(1, 255)) : 8'($urandom));
  endfunction

  // Directed: key and value extremes, all operations, error paths
  task automatic test_directed();
    logic [7:0] k[$];
    logic [7:0] v[$];
    logic [7:0] e[$];
    k = '{8'h01}; v = '{};
    run_op(kvt_pkg::MODE_SET, k, v);                // single-byte key, empty value
    run_op(kvt_pkg::MODE_GET, k, v, 0);             // empty value, zero capacity
    k = '{8'hFF, 8'h80}; v = '{8'h00, 8'hFF, 8'h55};
    run_op(kvt_pkg::MODE_SET, k, v);
    run_op(kvt_pkg::MODE_GET, k, e, 2);             // capacity too small
    run_op(kvt_pkg::MODE_GET, k, e, 3);
    make_bytes(k, 15, 1); make_bytes(v, 32, 0);
    run_op(kvt_pkg::MODE_SET, k, v);                // longest key, longest value
    run_op(kvt_pkg::MODE_GET, k, e);
    run_op(kvt_pkg::MODE_LIST, e, e, 0, 2);
    make_bytes(v, 33, 0);
    run_op(kvt_pkg::MODE_SET, e, v);                // oversized value beats empty key
    make_bytes(k, 18, 1);
    run_op(kvt_pkg::MODE_SET, k, e);                // too-long key
    run_op(kvt_pkg::MODE_SET, e, e);                // empty key
    // zero byte ends the key; trailing bytes dropped
    send_word(kvt_pkg::MODE_SET, kvt_pkg::PART_KEY, 8'h01);
    send_word(kvt_pkg::MODE_SET, kvt_pkg::PART_KEY, 8'h00);
    send_word(kvt_pkg::MODE_SET, kvt_pkg::PART_KEY, 8'h77);
    send_word(kvt_pkg::MODE_SET, kvt_pkg::PART_VALUE, 8'h42);
    send_word(kvt_pkg::MODE_SET, kvt_pkg::PART_NONE, 8'h12);  // ignored word
    send_word(kvt_pkg::MODE_SET, kvt_pkg::PART_EXEC, 8'h00);  // overwrite existing key
    k = '{8'h01}; run_op(kvt_pkg::MODE_GET, k, e);
    run_op(kvt_pkg::MODE_LIST, e, e, 0, 15);        // rank out of range
    v = '{8'h99}; run_op(kvt_pkg::MODE_REMOVE, k, v);   // value bytes ignored
    run_op(kvt_pkg::MODE_REMOVE, k, e);             // not found
  endtask

  // Fill past capacity, list every fifth rank, remove every other key
  task automatic test_full_table();
    logic [7:0] k[$];
    logic [7:0] v[$];
    logic [7:0] e[$];
    for (int i = 0; i < NSLOT + 1; i++) begin
      k = '{8'(i + 1)}; make_bytes(v, $urandom_range(0, 1), 0);
      run_op(kvt_pkg::MODE_SET, k, v);
    end
    for (int r = 0; r < NSLOT; r += 5) run_op(kvt_pkg::MODE_LIST, e, e, 0, r[3:0]);
    for (int i = 0; i < NSLOT; i += 2) begin
      k = '{8'(i + 1)}; run_op(kvt_pkg::MODE_REMOVE, k, e);
    end
  endtask

  // Random operations, mostly on a small key pool, plus noise words
  task automatic test_random(int n_items);
    logic [7:0] k[$];
    logic [7:0] v[$];
    int sent;
    int sel;
    kvt_pkg::mode_t m;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(0, 9);
      m = kvt_pkg::mode_t'($urandom_range(0, 3));
      if (sel == 0) begin
        send_word(kvt_pkg::mode_t'($urandom_range(0, 3)),
                  kvt_pkg::part_t'($urandom_range(0, 3)),
                  8'($urandom), 16'($urandom), 4'($urandom));
        sent++;
        continue;
      end
      if (sel < 8) k = '{8'($urandom_range(1, 4)), 8'hC3};
      else make_bytes(k, $urandom_range(0, 17), sel == 8);
      if (m == kvt_pkg::MODE_SET || sel == 9)
        make_bytes(v, $urandom_range(0, 3) == 0 ? $urandom_range(0, 34) :
                                                  $urandom_range(0, 3), 0);
      else v.delete();
      run_op(m, k, v, $urandom_range(0, 1) ? 16'($urandom_range(0, 8)) : 16'($urandom),
             4'($urandom));
      sent += k.size() + v.size() + 1;
    end
  endtask

  initial begin
    in_ch.valid = 0; in_ch.mode = kvt_pkg::MODE_SET; in_ch.part = kvt_pkg::PART_KEY;
    in_ch.data = 0; in_ch.capacity = 0; in_ch.rank = 0;
    rst_n = 0; errors = 0; results_seen = 0; ops_sent = 0; cycles = 0;
    tbl_count = 0; stg_kcnt = 0; stg_vcnt = 0; stg_ended = 0;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_used[i] = 0; tbl_klen[i] = 0; tbl_vlen[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random(30);
    in_ch.valid <= 0;
    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk);
    $display("Ran %0d operations, checked %0d result words", ops_sent, results_seen);
    $display("Covered set/get/remove/list, full table, bad keys and oversized values");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/kvt_pkg.sv
design/kvt_ifs.sv
design/kvt_ram.sv
design/kvt_stage.sv
design/kvt_seq.sv
design/attribute_key_value_table.sv
tb/sv/tb.sv
